// ----- rtl/core/qmn_pkg.sv -----
`default_nettype none

package qmn_pkg;

  // Width of a scaled component magnitude: the largest lands in [2^29, 2^30)
  localparam int SCALED_BITS = 30;
  // Sum of four squared scaled magnitudes
  localparam int SUM_BITS = 2 * SCALED_BITS + 2;
  // Integer square root of the sum
  localparam int ROOT_BITS = SUM_BITS / 2;
  // Partial remainder of the square root recurrence
  localparam int SQ_REM_BITS = ROOT_BITS + 2;
  // Divisor is twice the length
  localparam int DIV_BITS = ROOT_BITS + 1;
  // Partial remainder of the division recurrence
  localparam int DIV_REM_BITS = DIV_BITS + 1;
  // Lanes (w, x, y, z)
  localparam int LANES = 4;

  // Per-item data that rides along the root and divide stages
  typedef struct packed {
    logic [LANES-1:0][SCALED_BITS-1:0] mag;
    logic [LANES-1:0]                  neg;
    logic                              zero;
  } carry_t;

endpackage

`default_nettype wire

// ----- rtl/core/quaternion_multiply_normalize.sv -----
`default_nettype none

// Normalized Hamilton product r = (a*b)/|a*b| of two quaternions with signed
// fixed-point components of COMPONENT_BITS bits (Q1.15 at the default). The
// product is exact, block-scaled so its largest magnitude sits in [2^29, 2^30),
// its length is an integer square root, and each component is divided by the
// length, rounded half away from zero and saturated to +/-(2^(COMPONENT_BITS-1)-1).
// A zero product gives zero components with tuser (zero_length) set. The core is
// a fully pipelined datapath: one item per clock while the skid register is empty,
// with 9 product/scaling stages, 31 square root stages, one divide setup stage,
// COMPONENT_BITS divide stages and one output register, in that order. The square
// root and the divide each retire one result bit per stage. A skid register
// behind the output register takes the item that leaves the pipeline while the
// output is stalled, so input transfers go on until the skid register is full.
module quaternion_multiply_normalize #(
  parameter int COMPONENT_BITS = 16
) (
  input  wire                            clk,
  input  wire                            rst,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z (lowest first)
  input  wire [8*COMPONENT_BITS-1:0]     s_axis_tdata,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // r_w, r_x, r_y, r_z (lowest first), zero padded to bytes
  output logic [((4*COMPONENT_BITS+7)/8)*8-1:0] m_axis_tdata,
  // zero_length
  output logic                           m_axis_tuser,
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready
);

  localparam int CB   = COMPONENT_BITS;
  localparam int OPW  = (CB > 30) ? 30 : CB;
  localparam int F    = CB - 1;
  localparam int PW   = 2 * OPW;
  localparam int CW   = PW + 2;
  localparam int MW   = CW - 1;
  localparam int NG   = (MW + 7) / 8;
  localparam int PB   = $clog2(NG * 8);
  localparam int QW   = F + 1;
  localparam int ODW  = ((4 * CB + 7) / 8) * 8;
  localparam int SW   = qmn_pkg::SCALED_BITS;
  localparam int NL   = qmn_pkg::LANES;
  localparam int RB   = qmn_pkg::ROOT_BITS;
  localparam int SQB  = qmn_pkg::SUM_BITS;
  localparam int SRB  = qmn_pkg::SQ_REM_BITS;
  localparam int DRB  = qmn_pkg::DIV_REM_BITS;

  logic adv;
  logic k_valid;

  assign adv           = !k_valid;
  assign s_axis_tready = !k_valid;

  // Operand fetch: keep the top OPW bits of each field
  logic signed [OPW-1:0] opa [NL];
  logic signed [OPW-1:0] opb [NL];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      opa[i] = s_axis_tdata[i*CB + CB - 1 -: OPW];
      opb[i] = s_axis_tdata[(i+4)*CB + CB - 1 -: OPW];
    end
  end

  // Stage 1: the sixteen partial products
  logic v1;
  logic signed [PW-1:0] prod [16];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod[0]  <= opa[0] * opb[0];
      prod[1]  <= opa[1] * opb[1];
      prod[2]  <= opa[2] * opb[2];
      prod[3]  <= opa[3] * opb[3];
      prod[4]  <= opa[0] * opb[1];
      prod[5]  <= opa[1] * opb[0];
      prod[6]  <= opa[2] * opb[3];
      prod[7]  <= opa[3] * opb[2];
      prod[8]  <= opa[0] * opb[2];
      prod[9]  <= opa[2] * opb[0];
      prod[10] <= opa[3] * opb[1];
      prod[11] <= opa[1] * opb[3];
      prod[12] <= opa[0] * opb[3];
      prod[13] <= opa[3] * opb[0];
      prod[14] <= opa[1] * opb[2];
      prod[15] <= opa[2] * opb[1];
    end
  end

  // Stage 2: Hamilton sums
  logic v2;
  logic signed [CW-1:0] pe [16];
  logic signed [CW-1:0] cs [NL];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      pe[i] = CW'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs[0] <= pe[0] - pe[1] - pe[2] - pe[3];
      cs[1] <= pe[4] + pe[5] + pe[6] - pe[7];
      cs[2] <= pe[8] + pe[9] + pe[10] - pe[11];
      cs[3] <= pe[12] + pe[13] + pe[14] - pe[15];
    end
  end

  // Stage 3: sign and magnitude; OR of magnitudes has the max's leading one
  logic v3;
  logic [MW-1:0] mag3 [NL];
  logic [NL-1:0] neg3;
  logic [NG*8-1:0] orw3;
  logic [MW-1:0] mag_n [NL];
  logic [NG*8-1:0] orw_n;

  always_comb begin
    orw_n = '0;
    for (int i = 0; i < NL; i++) begin
      mag_n[i] = cs[i][CW-1] ? MW'(-cs[i]) : MW'(cs[i]);
      orw_n    = orw_n | (NG*8)'(mag_n[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NL; i++) begin
        mag3[i] <= mag_n[i];
        neg3[i] <= cs[i][CW-1];
      end
      orw3 <= orw_n;
    end
  end

  // Stage 4: leading one inside each byte group
  logic v4;
  logic [MW-1:0] mag4 [NL];
  logic [NL-1:0] neg4;
  logic [NG-1:0] gnz;
  logic [2:0]    gpos [NG];
  logic [NG-1:0] gnz_n;
  logic [2:0]    gpos_n [NG];

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      gnz_n[g]  = |orw3[g*8 +: 8];
      gpos_n[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (orw3[g*8 + b]) begin
          gpos_n[g] = 3'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag4 <= mag3;
      neg4 <= neg3;
      gnz  <= gnz_n;
      gpos <= gpos_n;
    end
  end

  // Stage 5: pick the highest nonzero group
  logic v5;
  logic [MW-1:0] mag5 [NL];
  logic [NL-1:0] neg5;
  logic [PB-1:0] lead5;
  logic          zero5;
  logic [PB-1:0] lead_n;

  always_comb begin
    lead_n = '0;
    for (int g = 0; g < NG; g++) begin
      if (gnz[g]) begin
        lead_n = PB'(g * 8) | PB'(gpos[g]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag5  <= mag4;
      neg5  <= neg4;
      lead5 <= lead_n;
      zero5 <= !(|gnz);
    end
  end

  // Stage 6: block scaling, leading one of the max goes to bit SW-1
  logic v6;
  qmn_pkg::carry_t c6;
  logic [MW+SW-2:0] wide [NL];
  logic [MW+SW-2:0] shf  [NL];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      wide[i] = {mag5[i], {(SW-1){1'b0}}};
      shf[i]  = wide[i] >> lead5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NL; i++) begin
        c6.mag[i] <= shf[i][SW-1:0];
      end
      c6.neg  <= neg5;
      c6.zero <= zero5;
    end
  end

  // Stage 7: squares
  logic v7;
  qmn_pkg::carry_t c7;
  logic [2*SW-1:0] sq7 [NL];

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NL; i++) begin
        sq7[i] <= c6.mag[i] * c6.mag[i];
      end
      c7 <= c6;
    end
  end

  // Stage 8: pair sums
  logic v8;
  qmn_pkg::carry_t c8;
  logic [2*SW:0] ps8 [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ps8[0] <= (2*SW+1)'(sq7[0]) + (2*SW+1)'(sq7[1]);
      ps8[1] <= (2*SW+1)'(sq7[2]) + (2*SW+1)'(sq7[3]);
      c8     <= c7;
    end
  end

  // Stage 9: total sum of squares, seeds the square root pipeline
  logic            sq_v    [0:RB];
  qmn_pkg::carry_t sq_c    [0:RB];
  logic [SQB-1:0]  sq_sum  [0:RB];
  logic [SRB-1:0]  sq_rem  [0:RB];
  logic [RB-1:0]   sq_root [0:RB];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_sum[0]  <= SQB'(ps8[0]) + SQB'(ps8[1]);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_c[0]    <= c8;
    end
  end

  // Square root: one root bit per stage, most significant first
  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    localparam int J = RB - 1 - k;
    logic [SRB+1:0] t;
    logic [SRB+1:0] trial;
    logic           take;

    always_comb begin
      t     = {sq_rem[k], sq_sum[k][2*J+1 -: 2]};
      trial = {2'b00, sq_root[k], 2'b01};
      take  = (t >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[k+1]  <= take ? SRB'(t - trial) : SRB'(t);
        sq_root[k+1] <= {sq_root[k][RB-2:0], take};
        sq_sum[k+1]  <= sq_sum[k];
        sq_c[k+1]    <= sq_c[k];
      end
    end
  end

  // Divide setup: remainder starts at m + (L >> (F+1)), low numerator bits are L
  logic            dv_v [0:QW];
  qmn_pkg::carry_t dv_c [0:QW];
  logic [RB:0]     dv_l [0:QW];
  logic [DRB-1:0]  dv_r [0:QW][NL];
  logic [QW-1:0]   dv_q [0:QW][NL];
  logic [RB:0]     lx;

  assign lx = {1'b0, sq_root[RB]};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= sq_v[RB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NL; i++) begin
        dv_r[0][i] <= DRB'(sq_c[RB].mag[i]) + DRB'(lx >> (F + 1));
        dv_q[0][i] <= '0;
      end
      dv_l[0] <= lx;
      dv_c[0] <= sq_c[RB];
    end
  end

  // Divide by 2L: one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int J = F - k;
    logic [DRB:0] t   [NL];
    logic [DRB:0] dd;
    logic [NL-1:0] take;

    always_comb begin
      dd = {1'b0, dv_l[k], 1'b0};
      for (int i = 0; i < NL; i++) begin
        t[i]    = {dv_r[k][i], dv_l[k][J]};
        take[i] = (t[i] >= dd);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < NL; i++) begin
          dv_r[k+1][i] <= take[i] ? DRB'(t[i] - dd) : DRB'(t[i]);
          dv_q[k+1][i] <= {dv_q[k][i][QW-2:0], take[i]};
        end
        dv_l[k+1] <= dv_l[k];
        dv_c[k+1] <= dv_c[k];
      end
    end
  end

  // Saturate, restore sign, force zeros for a zero-length product
  localparam logic [QW-1:0] LIMIT = {1'b0, {F{1'b1}}};

  logic [QW-1:0]   qsat [NL];
  logic [CB-1:0]   comp [NL];
  logic [ODW-1:0]  res_data;
  logic            res_zero;

  always_comb begin
    res_data = '0;
    res_zero = dv_c[QW].zero;
    for (int i = 0; i < NL; i++) begin
      qsat[i] = (dv_q[QW][i] > LIMIT) ? LIMIT : dv_q[QW][i];
      if (res_zero) begin
        comp[i] = '0;
      end else if (dv_c[QW].neg[i]) begin
        comp[i] = CB'(-qsat[i]);
      end else begin
        comp[i] = CB'(qsat[i]);
      end
      res_data[i*CB +: CB] = comp[i];
    end
  end

  // Output register with skid register
  logic [ODW-1:0] k_data;
  logic           k_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      k_valid       <= 1'b0;
    end else if (k_valid) begin
      if (m_axis_tready) begin
        k_valid <= 1'b0;
      end
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= dv_v[QW];
    end else if (dv_v[QW]) begin
      k_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (k_valid) begin
      if (m_axis_tready) begin
        m_axis_tdata <= k_data;
        m_axis_tuser <= k_zero;
      end
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tdata <= res_data;
      m_axis_tuser <= res_zero;
    end else begin
      k_data <= res_data;
      k_zero <= res_zero;
    end
  end

  // Checks
  a_skid_implies_out : assert property (@(posedge clk) disable iff (rst)
    k_valid |-> m_axis_tvalid)
    else $error("skid register full without a pending output");

  a_zero_gives_zeros : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("zero-length result with nonzero components");

  a_no_min_value : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tdata[0*CB +: CB] != {1'b1, {F{1'b0}}}) &&
      (m_axis_tdata[1*CB +: CB] != {1'b1, {F{1'b0}}}) &&
      (m_axis_tdata[2*CB +: CB] != {1'b1, {F{1'b0}}}) &&
      (m_axis_tdata[3*CB +: CB] != {1'b1, {F{1'b0}}}))
    else $error("component outside saturation range");

  a_pipe_frozen : assert property (@(posedge clk) disable iff (rst)
    (k_valid && !m_axis_tready) |=> $stable(dv_v[QW]))
    else $error("pipeline moved while skid register full");

endmodule

`default_nettype wire
